>>> hw/rtl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types, codes and constants for the flash command device.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

    // Store and page geometry
    localparam int unsigned FCD_STORE_BYTES = 131072;
    localparam int unsigned PAGE_BYTES      = 128;
    localparam int unsigned WORD_BYTES      = 4;
    localparam int unsigned PAGE_WORDS      = PAGE_BYTES / WORD_BYTES;
    localparam int unsigned PW_W            = $clog2(PAGE_WORDS);
    localparam int unsigned PAGE_SH         = $clog2(PAGE_BYTES);
    localparam int unsigned ADD_W           = 8;

    // Configuration port
    localparam int unsigned PADDR_W          = 3;
    localparam int unsigned FLASH_SIZE_W     = 18;
    localparam logic [FLASH_SIZE_W-1:0] FLASH_SIZE_RESET = 18'd131072;
    localparam logic        REG_FLASH_SIZE   = 1'b0;

    // Fixed words
    localparam logic [31:0] STATUS_ADDR   = 32'h0800_0000;
    localparam logic [31:0] STATUS_IDENT  = 32'h1111_8001;
    localparam logic [31:0] STATUS_ERASE  = 32'h1111_8008;
    localparam logic [31:0] STATUS_RW     = 32'h1111_8004;
    localparam logic [31:0] FLASH_ID      = 32'h00C2_001D;
    localparam logic [31:0] BLANK_WORD    = 32'hFFFF_FFFF;
    localparam logic [31:0] OFFSET_CHIP   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_CMD     = 2'd0,
        FUNC_REG_RD  = 2'd1,
        FUNC_WORD_RD = 2'd2,
        FUNC_PAGE_LD = 2'd3
    } fcd_func_t;

    typedef enum logic [7:0] {
        CMD_NONE         = 8'h00,
        CMD_CHIP_SEL     = 8'h3C,
        CMD_SET_OFFSET   = 8'h4B,
        CMD_ERASE        = 8'h78,
        CMD_WRITE_OFFSET = 8'hA5,
        CMD_WRITE        = 8'hB4,
        CMD_EXECUTE      = 8'hD2,
        CMD_IDENT        = 8'hE1,
        CMD_READ         = 8'hF0
    } fcd_cmd_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_READ  = 3'd2,
        MODE_WRITE = 3'd3,
        MODE_ERASE = 3'd4
    } fcd_mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_CHK_RD,
        ST_RD_DATA,
        ST_CHK_PG,
        ST_PROG_RD,
        ST_PROG_WR,
        ST_FILL,
        ST_DONE
    } fcd_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/fcd_req_if.sv
// ----------------------------------------------------------------------------
// fcd_req_if
// Bus transaction channel into the flash command device.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fcd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] address;
    logic [31:0] data;
    logic [4:0]  word_index;

    modport source (output valid, func, address, data, word_index, input ready);
    modport sink   (input valid, func, address, data, word_index, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fcd_rsp_if.sv
// ----------------------------------------------------------------------------
// fcd_rsp_if
// Result channel out of the flash command device.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fcd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        data_valid;
    logic        error;

    modport source (output valid, read_data, data_valid, error, input ready);
    modport sink   (input valid, read_data, data_valid, error, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fcd_ram.sv
// ----------------------------------------------------------------------------
// fcd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/flash_command_device_core.sv
// ----------------------------------------------------------------------------
// flash_command_device_core
// Command-driven cartridge save flash with page buffer and word store.
// ----------------------------------------------------------------------------
// Usage:
//   req  : bus transactions (command write, register read, flash word read,
//          page word load). Accepted on valid & ready.
//   rsp  : exactly one result transaction per request, held in an output
//          register until taken; a new request is accepted while it waits.
//   APB  : flash_size at offset 0 (bits 17:0). Write only while idle.
// Steps (accept to result registered; the device is idle again as the result is registered):
//   command / register read / page load / ident read : execute step only
//   word read in read mode  : bound check, then store read
//   page program            : bound check, then per word a buffer read and a store write
//   page erase              : bound check, then fill walk over the page, one word a cycle
//   chip erase              : fill walk over every whole usable page, one word a cycle
//   All walks share the single store write port; the bound check is one
//   33-bit add/compare shared by reads and page operations.
// Reset: the store is filled with all ones, one word a cycle, over all
//   STORE_BYTES/4 words (32768 by default); req.ready stays low meanwhile.
// Stall: if rsp is not taken, the next request is processed up to its result
//   and then waits for the output register to free up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flash_command_device_core #(
    parameter int unsigned STORE_BYTES = fcd_pkg::FCD_STORE_BYTES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    fcd_req_if.sink                          req,
    fcd_rsp_if.source                        rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fcd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    import fcd_pkg::*;

    localparam int unsigned STORE_WORDS = STORE_BYTES / WORD_BYTES;
    localparam int unsigned AW          = $clog2(STORE_WORDS);
    localparam int unsigned CNT_W       = AW + 1;
    localparam int unsigned USE_W       = $clog2(STORE_BYTES + 1);
    localparam int unsigned SZ_W        = (USE_W > FLASH_SIZE_W) ? USE_W : FLASH_SIZE_W;

    // Control and architectural state
    fcd_state_t             state_reg, state_next;
    fcd_mode_t              mode_reg, mode_next;
    logic [31:0]            status_reg, status_next;
    logic [31:0]            page_offset_reg, page_offset_next;
    logic [FLASH_SIZE_W-1:0] flash_size_reg;
    logic [AW-1:0]          fill_addr_reg, fill_addr_next;
    logic [CNT_W-1:0]       fill_left_reg, fill_left_next;
    logic [PW_W-1:0]        cnt_reg, cnt_next;
    logic                   blank_reg, blank_next;
    logic                   out_valid_reg, out_valid_next;

    // Latched request
    fcd_func_t              func_reg;
    logic [31:0]            addr_reg;
    logic [31:0]            data_reg;
    logic [PW_W-1:0]        widx_reg;

    // Bound unit operands
    logic [31:0]            op_a_reg, op_a_next;
    logic [ADD_W-1:0]       addend_reg, addend_next;

    // Result staging and output register
    logic [31:0]            res_rd_reg, res_rd_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_err_reg, res_err_next;
    logic [31:0]            out_rd_reg, out_rd_next;
    logic                   out_dv_reg, out_dv_next;
    logic                   out_err_reg, out_err_next;

    // Memories
    logic                   store_we, store_re;
    logic [AW-1:0]          store_waddr;
    logic [31:0]            store_wdata, store_q;
    logic                   pbuf_we, pbuf_re;
    logic [31:0]            pbuf_q;

    // Decode
    logic [SZ_W-1:0]        size_ext;
    logic [USE_W-1:0]       usable;
    logic [USE_W-PAGE_SH-1:0] chip_pages;
    logic [CNT_W-1:0]       chip_words;
    logic                   chip_empty;
    fcd_cmd_t               cmd;
    logic                   is_exec;
    logic                   exec_chip;
    logic                   exec_page;
    logic [32:0]            bound_sum;
    logic                   fits;
    logic                   req_acc;
    logic                   out_free;
    logic                   cfg_we;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_FLASH_SIZE);
    assign prdata = (paddr[2] == REG_FLASH_SIZE) ? 32'(flash_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_size_reg <= FLASH_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            flash_size_reg <= pwdata[FLASH_SIZE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Decode and shared bound unit
    // ------------------------------------------------------------------
    always_comb
    begin
        size_ext   = SZ_W'(flash_size_reg);
        usable     = (size_ext > SZ_W'(STORE_BYTES)) ? USE_W'(STORE_BYTES)
                                                     : USE_W'(size_ext);
        chip_pages = usable[USE_W-1:PAGE_SH];
        chip_words = CNT_W'({chip_pages, PW_W'(0)});
        chip_empty = (chip_pages == '0);
        cmd        = fcd_cmd_t'(data_reg[31:24]);
        is_exec    = (func_reg == FUNC_CMD) && (cmd == CMD_EXECUTE);
        exec_chip  = is_exec && (mode_reg == MODE_ERASE) && (page_offset_reg == OFFSET_CHIP);
        exec_page  = is_exec && ((mode_reg == MODE_WRITE) ||
                     ((mode_reg == MODE_ERASE) && (page_offset_reg != OFFSET_CHIP)));
        // offset + length must not pass the usable size
        bound_sum  = {1'b0, op_a_reg} + 33'(addend_reg);
        fits       = (bound_sum <= 33'(usable));
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid & req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (fill_left_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_page)
                begin
                    state_next = ST_CHK_PG;
                end
                else if (exec_chip && !chip_empty)
                begin
                    state_next = ST_FILL;
                end
                else if ((func_reg == FUNC_WORD_RD) && (mode_reg == MODE_READ))
                begin
                    state_next = ST_CHK_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CHK_RD:
            begin
                state_next = fits ? ST_RD_DATA : ST_DONE;
            end
            ST_RD_DATA:
            begin
                state_next = ST_DONE;
            end
            ST_CHK_PG:
            begin
                if (!fits)
                begin
                    state_next = ST_DONE;
                end
                else if (blank_reg)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_PROG_RD;
                end
            end
            ST_PROG_RD:
            begin
                state_next = ST_PROG_WR;
            end
            ST_PROG_WR:
            begin
                if (cnt_reg == PW_W'(PAGE_WORDS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PROG_RD;
                end
            end
            ST_FILL:
            begin
                if (fill_left_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next        = mode_reg;
        status_next      = status_reg;
        page_offset_next = page_offset_reg;
        fill_addr_next   = fill_addr_reg;
        fill_left_next   = fill_left_reg;
        cnt_next         = cnt_reg;
        blank_next       = blank_reg;
        op_a_next        = op_a_reg;
        addend_next      = addend_reg;
        res_rd_next      = res_rd_reg;
        res_valid_next   = res_valid_reg;
        res_err_next     = res_err_reg;
        out_rd_next      = out_rd_reg;
        out_dv_next      = out_dv_reg;
        out_err_next     = out_err_reg;
        out_valid_next   = out_valid_reg;
        store_we         = 1'b0;
        store_re         = 1'b0;
        store_waddr      = fill_addr_reg;
        store_wdata      = BLANK_WORD;
        pbuf_we          = 1'b0;
        pbuf_re          = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR, ST_FILL:
            begin
                store_we       = 1'b1;
                fill_addr_next = fill_addr_reg + AW'(1);
                fill_left_next = fill_left_reg - CNT_W'(1);
            end
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                res_rd_next    = '0;
                res_valid_next = 1'b0;
                res_err_next   = 1'b0;
                unique case (func_reg)
                    FUNC_CMD:
                    begin
                        if (data_reg == '0)
                        begin
                            status_next = '0;
                        end
                        unique case (cmd)
                            CMD_EXECUTE:
                            begin
                                mode_next      = MODE_IDLE;
                                op_a_next      = page_offset_reg;
                                addend_next    = ADD_W'(PAGE_BYTES);
                                blank_next     = (mode_reg == MODE_ERASE);
                                fill_addr_next = '0;
                                fill_left_next = chip_words;
                            end
                            CMD_NONE:
                            begin
                            end
                            CMD_IDENT:
                            begin
                                mode_next   = MODE_IDENT;
                                status_next = STATUS_IDENT;
                            end
                            CMD_CHIP_SEL:
                            begin
                                page_offset_next = OFFSET_CHIP;
                            end
                            CMD_SET_OFFSET:
                            begin
                                page_offset_next = {1'b0, data_reg[23:0], PAGE_SH'(0)};
                            end
                            CMD_ERASE:
                            begin
                                mode_next   = MODE_ERASE;
                                status_next = STATUS_ERASE;
                            end
                            CMD_WRITE:
                            begin
                                mode_next = MODE_WRITE;
                            end
                            CMD_WRITE_OFFSET:
                            begin
                                mode_next        = MODE_WRITE;
                                page_offset_next = {1'b0, data_reg[23:0], PAGE_SH'(0)};
                                status_next      = STATUS_RW;
                            end
                            CMD_READ:
                            begin
                                mode_next   = MODE_READ;
                                status_next = STATUS_RW;
                            end
                            default:
                            begin
                                res_err_next = 1'b1;
                            end
                        endcase
                    end
                    FUNC_REG_RD:
                    begin
                        // anything but the status address reads back as open bus
                        res_rd_next = (addr_reg == STATUS_ADDR) ? status_reg
                                                                : {addr_reg[15:0], addr_reg[15:0]};
                    end
                    FUNC_WORD_RD:
                    begin
                        if (mode_reg == MODE_IDENT)
                        begin
                            if (addr_reg[31:2] == 30'd0)
                            begin
                                res_rd_next    = status_reg;
                                res_valid_next = 1'b1;
                            end
                            else if (addr_reg[31:2] == 30'd1)
                            begin
                                res_rd_next    = FLASH_ID;
                                res_valid_next = 1'b1;
                            end
                        end
                        op_a_next   = {addr_reg[31:2], 2'b00};
                        addend_next = ADD_W'(WORD_BYTES);
                    end
                    FUNC_PAGE_LD:
                    begin
                        pbuf_we = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CHK_RD:
            begin
                if (fits)
                begin
                    store_re = 1'b1;
                end
                else
                begin
                    res_err_next = 1'b1;
                end
            end
            ST_RD_DATA:
            begin
                res_rd_next    = store_q;
                res_valid_next = 1'b1;
            end
            ST_CHK_PG:
            begin
                cnt_next       = '0;
                fill_addr_next = {page_offset_reg[AW+1:PAGE_SH], PW_W'(0)};
                fill_left_next = CNT_W'(PAGE_WORDS);
                if (!fits)
                begin
                    res_err_next = 1'b1;
                end
            end
            ST_PROG_RD:
            begin
                pbuf_re = 1'b1;
            end
            ST_PROG_WR:
            begin
                store_we    = 1'b1;
                store_waddr = {page_offset_reg[AW+1:PAGE_SH], cnt_reg};
                store_wdata = pbuf_q;
                cnt_next    = cnt_reg + PW_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = res_rd_reg;
                    out_dv_next    = res_valid_reg;
                    out_err_next   = res_err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            mode_reg        <= MODE_IDLE;
            status_reg      <= '0;
            page_offset_reg <= '0;
            fill_addr_reg   <= '0;
            fill_left_reg   <= CNT_W'(STORE_WORDS);
            cnt_reg         <= '0;
            blank_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            status_reg      <= status_next;
            page_offset_reg <= page_offset_next;
            fill_addr_reg   <= fill_addr_next;
            fill_left_reg   <= fill_left_next;
            cnt_reg         <= cnt_next;
            blank_reg       <= blank_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            func_reg <= fcd_func_t'(req.func);
            addr_reg <= req.address;
            data_reg <= req.data;
            widx_reg <= req.word_index;
        end
        op_a_reg      <= op_a_next;
        addend_reg    <= addend_next;
        res_rd_reg    <= res_rd_next;
        res_valid_reg <= res_valid_next;
        res_err_reg   <= res_err_next;
        out_rd_reg    <= out_rd_next;
        out_dv_reg    <= out_dv_next;
        out_err_reg   <= out_err_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_rd_reg;
    assign rsp.data_valid = out_dv_reg;
    assign rsp.error      = out_err_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    fcd_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (addr_reg[AW+1:2]),
        .rdata (store_q)
    );

    fcd_ram #(
        .WIDTH (32),
        .DEPTH (PAGE_WORDS)
    ) u_pbuf (
        .clk   (clk),
        .we    (pbuf_we),
        .waddr (widx_reg),
        .wdata (data_reg),
        .re    (pbuf_re),
        .raddr (cnt_reg),
        .rdata (pbuf_q)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_store_we_walk: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (state_reg == ST_FILL || state_reg == ST_CLEAR ||
                      state_reg == ST_PROG_WR))
        else $error("store written outside a walk");

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL || state_reg == ST_CLEAR) |-> (fill_left_reg != '0))
        else $error("fill walk with nothing left");

    a_exec_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK_PG || state_reg == ST_PROG_WR) |-> (mode_reg == MODE_IDLE))
        else $error("mode not idle during page operation");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_valid_reg) |-> !res_err_reg)
        else $error("result with both data valid and error");

    a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not handed to output register");

endmodule

`default_nettype wire
